// ----- rtl/sample_dma_buffer_cache_unit_assert.svh -----
// Assertion macros for the sample DMA buffer cache.
// Used by the top level; needs clk_i and rst_ni in scope.
`ifndef SAMPLE_DMA_BUFFER_CACHE_UNIT_ASSERT_SVH
`define SAMPLE_DMA_BUFFER_CACHE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SDBC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sdbc assertion failed");

// Next-cycle implication.
`define SDBC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sdbc assertion failed");

`endif

// ----- rtl/sdbc_pkg.sv -----
// Package for the sample DMA buffer cache: payload types, opcodes and defaults.
// No dependencies.
package sdbc_pkg;

  localparam int unsigned NumSlotsDef  = 32;
  localparam int unsigned SlotBytesDef = 2048;

  localparam logic OP_FETCH = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef struct packed {
    logic        op;
    logic [31:0] rom_address;
    logic [15:0] byte_length;
  } req_t;

  typedef struct packed {
    logic [4:0]  slot;
    logic [11:0] offset;
    logic        hit;
    logic        dma_start;
    logic [31:0] dma_source;
    logic [7:0]  dma_tag;
    logic        out_of_buffers;
  } res_t;

endpackage

// ----- rtl/sample_dma_buffer_cache_unit.sv -----
// Top level of the sample DMA buffer cache.
// Depends on sdbc_pkg and sample_dma_buffer_cache_unit_assert.svh.

// A fetch transaction walks the address-ordered used list one slot per cycle
// through a single list-walk sequencer with one wide add-and-compare unit.
// On a hit the walk goes straight to the state that loads the output
// register; on a full cache the miss check comes first, and on a miss the
// miss check, slot allocation and list linking. The walk visits at most
// NUM_SLOTS slots. A tick transaction visits every used slot once, adds a
// free step for each slot it frees and a link step as well when the free
// list is not empty, and it produces no result. The block takes no new
// transaction until the current one is finished, but it accepts one while a
// previous result still waits on the output.
module sample_dma_buffer_cache_unit #(
  parameter int unsigned NUM_SLOTS  = sdbc_pkg::NumSlotsDef,
  parameter int unsigned SLOT_BYTES = sdbc_pkg::SlotBytesDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [7:0]     cfg_wdata_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  sdbc_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output sdbc_pkg::res_t out_data_o
);

  localparam int unsigned IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned PW = IW + 1;
  localparam int unsigned GW = $clog2(NUM_SLOTS + 1);
  localparam logic [PW-1:0] NIL = '1;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_WALK  = 4'd1;
  localparam logic [3:0] ST_MISS  = 4'd2;
  localparam logic [3:0] ST_ALLOC = 4'd3;
  localparam logic [3:0] ST_LINK  = 4'd4;
  localparam logic [3:0] ST_TWALK = 4'd5;
  localparam logic [3:0] ST_TFREE = 4'd6;
  localparam logic [3:0] ST_TLINK = 4'd7;
  localparam logic [3:0] ST_DONE  = 4'd8;

  function automatic logic ok(input logic [PW-1:0] s);
    return s < PW'(NUM_SLOTS);
  endfunction

  function automatic logic [IW-1:0] idx(input logic [PW-1:0] s);
    return s[IW-1:0];
  endfunction

  logic [3:0]     state_q, state_d;
  logic [PW-1:0]  s_q, s_d, last_q, last_d, nxt_q, nxt_d;
  logic [GW-1:0]  guard_q, guard_d;
  logic [PW-1:0]  used_q, used_d, free_q, free_d;
  logic [31:0]    frame_q, frame_d;
  logic [7:0]     dma_cnt_q, dma_cnt_d;
  logic [7:0]     lag_q;
  logic [31:0]    addr_q, addr_d;
  logic [32:0]    end_q, end_d;
  sdbc_pkg::res_t res_q, res_d, out_q, out_d;
  logic           out_valid_q, out_valid_d;

  logic [31:0]    start_q [NUM_SLOTS];
  logic [31:0]    lframe_q [NUM_SLOTS];
  logic [PW-1:0]  next_q [NUM_SLOTS];
  logic [PW-1:0]  prev_q [NUM_SLOTS];

  logic [PW-1:0]  nx_addr, pv_addr, nx_rd, pv_rd;
  logic [31:0]    start_rd, lf_rd, diff;
  logic           start_we, lf_we;
  logic           nwa_en, nwb_en, pwa_en, pwb_en;
  logic [PW-1:0]  nwa_addr, nwb_addr, pwa_addr, pwb_addr;
  logic [PW-1:0]  nwa_data, nwb_data, pwa_data, pwb_data;
  logic           guard_full;

  assign nx_rd      = next_q[idx(nx_addr)];
  assign pv_rd      = prev_q[idx(pv_addr)];
  assign start_rd   = start_q[idx(s_q)];
  assign lf_rd      = lframe_q[idx(s_q)];
  assign diff       = addr_q - start_rd;
  assign guard_full = (guard_q == GW'(NUM_SLOTS));

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    s_d         = s_q;
    last_d      = last_q;
    nxt_d       = nxt_q;
    guard_d     = guard_q;
    used_d      = used_q;
    free_d      = free_q;
    frame_d     = frame_q;
    dma_cnt_d   = dma_cnt_q;
    addr_d      = addr_q;
    end_d       = end_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    nx_addr     = s_q;
    pv_addr     = s_q;
    start_we    = 1'b0;
    lf_we       = 1'b0;
    nwa_en      = 1'b0;
    nwb_en      = 1'b0;
    pwa_en      = 1'b0;
    pwb_en      = 1'b0;
    nwa_addr    = s_q;
    nwb_addr    = s_q;
    pwa_addr    = s_q;
    pwb_addr    = s_q;
    nwa_data    = NIL;
    nwb_data    = NIL;
    pwa_data    = NIL;
    pwb_data    = NIL;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          s_d     = used_q;
          last_d  = NIL;
          guard_d = '0;
          addr_d  = in_data_i.rom_address;
          end_d   = {1'b0, in_data_i.rom_address} + {17'b0, in_data_i.byte_length};
          state_d = (in_data_i.op == sdbc_pkg::OP_TICK) ? ST_TWALK : ST_WALK;
        end
      end
      ST_WALK: begin
        if (!ok(s_q) || guard_full || (start_rd > addr_q)) begin
          state_d = ST_MISS;
        end else if (end_q <= ({1'b0, start_rd} + 33'(SLOT_BYTES))) begin
          lf_we        = 1'b1;
          res_d        = '0;
          res_d.slot   = 5'(idx(s_q));
          res_d.offset = diff[11:0];
          res_d.hit    = 1'b1;
          state_d      = ST_DONE;
        end else begin
          last_d  = s_q;
          s_d     = nx_rd;
          guard_d = guard_q + GW'(1);
        end
      end
      ST_MISS: begin
        if (!ok(free_q)) begin
          res_d = '0;
          if (ok(last_q)) begin
            res_d.slot = 5'(idx(last_q));
          end else if (ok(used_q)) begin
            res_d.slot = 5'(idx(used_q));
          end
          res_d.offset         = {11'b0, addr_q[0]};
          res_d.out_of_buffers = 1'b1;
          state_d              = ST_DONE;
        end else begin
          state_d = ST_ALLOC;
        end
      end
      ST_ALLOC: begin
        nx_addr  = free_q;
        pv_addr  = free_q;
        s_d      = free_q;
        free_d   = nx_rd;
        pwa_en   = ok(nx_rd);
        pwa_addr = nx_rd;
        pwa_data = pv_rd;
        nwa_en   = ok(pv_rd);
        nwa_addr = pv_rd;
        nwa_data = nx_rd;
        state_d  = ST_LINK;
      end
      ST_LINK: begin
        nx_addr  = last_q;
        nwa_en   = 1'b1;
        pwa_en   = 1'b1;
        if (ok(last_q)) begin
          nwa_data = nx_rd;
          pwa_data = last_q;
          pwb_en   = ok(nx_rd);
          pwb_addr = nx_rd;
          pwb_data = s_q;
          nwb_en   = 1'b1;
          nwb_addr = last_q;
          nwb_data = s_q;
        end else if (ok(used_q)) begin
          nwa_data = used_q;
          pwb_en   = 1'b1;
          pwb_addr = used_q;
          pwb_data = s_q;
          used_d   = s_q;
        end else begin
          used_d = s_q;
        end
        start_we         = 1'b1;
        lf_we            = 1'b1;
        res_d            = '0;
        res_d.slot       = 5'(idx(s_q));
        res_d.offset     = {11'b0, addr_q[0]};
        res_d.dma_start  = 1'b1;
        res_d.dma_source = {addr_q[31:1], 1'b0};
        res_d.dma_tag    = dma_cnt_q;
        if (dma_cnt_q != 8'hFF) begin
          dma_cnt_d = dma_cnt_q + 8'd1;
        end
        state_d = ST_DONE;
      end
      ST_TWALK: begin
        if (!ok(s_q) || guard_full) begin
          dma_cnt_d = '0;
          frame_d   = frame_q + 32'd1;
          state_d   = ST_IDLE;
        end else begin
          nxt_d = nx_rd;
          if ((lf_rd + {24'b0, lag_q}) < frame_q) begin
            state_d = ST_TFREE;
          end else begin
            s_d     = nx_rd;
            guard_d = guard_q + GW'(1);
          end
        end
      end
      ST_TFREE: begin
        if (used_q == s_q) begin
          used_d = nxt_q;
        end
        pwa_en   = ok(nxt_q);
        pwa_addr = nxt_q;
        pwa_data = pv_rd;
        nwa_en   = ok(pv_rd);
        nwa_addr = pv_rd;
        nwa_data = nxt_q;
        if (!ok(free_q)) begin
          free_d  = s_q;
          nwb_en  = 1'b1;
          pwb_en  = 1'b1;
          s_d     = nxt_q;
          guard_d = guard_q + GW'(1);
          state_d = ST_TWALK;
        end else begin
          state_d = ST_TLINK;
        end
      end
      ST_TLINK: begin
        nx_addr  = free_q;
        nwa_en   = 1'b1;
        nwa_data = nx_rd;
        pwa_en   = 1'b1;
        pwa_data = free_q;
        pwb_en   = ok(nx_rd);
        pwb_addr = nx_rd;
        pwb_data = s_q;
        nwb_en   = 1'b1;
        nwb_addr = free_q;
        nwb_data = s_q;
        s_d      = nxt_q;
        guard_d  = guard_q + GW'(1);
        state_d  = ST_TWALK;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      s_q         <= NIL;
      last_q      <= NIL;
      nxt_q       <= NIL;
      guard_q     <= '0;
      used_q      <= NIL;
      free_q      <= '0;
      frame_q     <= '0;
      dma_cnt_q   <= '0;
      lag_q       <= 8'd1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      s_q         <= s_d;
      last_q      <= last_d;
      nxt_q       <= nxt_d;
      guard_q     <= guard_d;
      used_q      <= used_d;
      free_q      <= free_d;
      frame_q     <= frame_d;
      dma_cnt_q   <= dma_cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        lag_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    end_q  <= end_d;
    res_q  <= res_d;
    out_q  <= out_d;
    if (start_we) begin
      start_q[idx(s_q)] <= {addr_q[31:1], 1'b0};
    end
    if (lf_we) begin
      lframe_q[idx(s_q)] <= frame_q;
    end
  end

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_link
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        next_q[i] <= (i + 1 < NUM_SLOTS) ? PW'(i + 1) : NIL;
        prev_q[i] <= (i > 0) ? PW'(i - 1) : NIL;
      end else begin
        if (nwa_en && (nwa_addr == PW'(i))) begin
          next_q[i] <= nwa_data;
        end
        if (nwb_en && (nwb_addr == PW'(i))) begin
          next_q[i] <= nwb_data;
        end
        if (pwa_en && (pwa_addr == PW'(i))) begin
          prev_q[i] <= pwa_data;
        end
        if (pwb_en && (pwb_addr == PW'(i))) begin
          prev_q[i] <= pwb_data;
        end
      end
    end
  end

`include "sample_dma_buffer_cache_unit_assert.svh"

  `SDBC_ASSERT_NEXT(a_accept_busy, in_valid_i && !in_stall_o, state_q != ST_IDLE)
  `SDBC_ASSERT_IMPL(a_kind_excl, out_valid_o,
                    !(out_data_o.dma_start && (out_data_o.hit || out_data_o.out_of_buffers)))
  `SDBC_ASSERT_IMPL(a_heads_apart, ok(free_q) && ok(used_q), free_q != used_q)
  `SDBC_ASSERT_IMPL(a_done_holds, state_q == ST_DONE && out_valid_q && out_stall_i,
                    state_d == ST_DONE)

endmodule

// ----- verif/sample_dma_buffer_cache_unit_test.sv -----
// Self-checking testbench for sample_dma_buffer_cache_unit: fetch and tick transactions
// are checked against a behavioral model of the slot lists held in a scoreboard class.
// Depends on sdbc_pkg and the RTL of the block.
`timescale 1ns / 100ps

module sample_dma_buffer_cache_unit_test;

  localparam int NSLOT = 32;
  localparam int SBYTES = 2048;
  localparam logic [7:0] NONE = 8'hFF;
  localparam int CYCLE_LIMIT = 2000000;

  class slot_cache_scoreboard;
    logic [31:0] start_addr[NSLOT];
    logic [31:0] last_frame[NSLOT];
    logic [7:0]  nxt[NSLOT];
    logic [7:0]  prv[NSLOT];
    logic [7:0]  used_head, free_head, dma_cnt, lag;
    logic [31:0] frame_cnt;
    sdbc_pkg::res_t pending[$];
    int          mismatches;
    int          checked;

    function void reset_state();
      for (int i = 0; i < NSLOT; i++) begin
        start_addr[i] = '0;
        last_frame[i] = '0;
        nxt[i] = (i + 1 < NSLOT) ? 8'(i + 1) : NONE;
        prv[i] = (i > 0) ? 8'(i - 1) : NONE;
      end
      used_head = NONE;
      free_head = '0;
      frame_cnt = '0;
      dma_cnt = '0;
      lag = 8'd1;
    endfunction

    function bit valid_slot(logic [7:0] s);
      return s < NSLOT;
    endfunction

    function void unlink(logic [7:0] s);
      logic [7:0] n, p;
      n = nxt[s[4:0]];
      p = prv[s[4:0]];
      if (valid_slot(n)) prv[n[4:0]] = p;
      if (valid_slot(p)) nxt[p[4:0]] = n;
    endfunction

    function void link_after(logic [7:0] s, logic [7:0] a);
      logic [7:0] n;
      n = nxt[a[4:0]];
      nxt[s[4:0]] = n;
      prv[s[4:0]] = a;
      if (valid_slot(n)) prv[n[4:0]] = s;
      nxt[a[4:0]] = s;
    endfunction

    function void frame_tick();
      logic [7:0] s, n;
      logic [31:0] lim;
      int guard;
      s = used_head;
      guard = 0;
      while (valid_slot(s) && guard < NSLOT) begin
        n = nxt[s[4:0]];
        lim = last_frame[s[4:0]] + 32'(lag);
        if (lim < frame_cnt) begin
          if (used_head == s) used_head = n;
          unlink(s);
          if (valid_slot(free_head)) link_after(s, free_head);
          else begin
            free_head = s;
            nxt[s[4:0]] = NONE;
            prv[s[4:0]] = NONE;
          end
        end
        s = n;
        guard++;
      end
      dma_cnt = '0;
      frame_cnt++;
    endfunction

    function void note_request(sdbc_pkg::req_t rq);
      sdbc_pkg::res_t r;
      logic [32:0] end_addr;
      logic [7:0] s, last, f;
      logic delta;
      int guard;
      if (rq.op == sdbc_pkg::OP_TICK) begin
        frame_tick();
        return;
      end
      r = '0;
      end_addr = 33'(rq.rom_address) + 33'(rq.byte_length);
      delta = rq.rom_address[0];
      s = used_head;
      last = NONE;
      guard = 0;
      while (valid_slot(s) && guard < NSLOT) begin
        if (start_addr[s[4:0]] > rq.rom_address) break;
        if (end_addr <= 33'(start_addr[s[4:0]]) + 33'(SBYTES)) begin
          last_frame[s[4:0]] = frame_cnt;
          r.slot = s[4:0];
          r.offset = 12'(rq.rom_address - start_addr[s[4:0]]);
          r.hit = 1'b1;
          pending.push_back(r);
          return;
        end
        last = s;
        s = nxt[s[4:0]];
        guard++;
      end
      f = free_head;
      if (!valid_slot(f)) begin
        if (!valid_slot(last)) last = used_head;
        r.slot = valid_slot(last) ? last[4:0] : 5'd0;
        r.offset = 12'(delta);
        r.out_of_buffers = 1'b1;
        pending.push_back(r);
        return;
      end
      free_head = nxt[f[4:0]];
      unlink(f);
      if (valid_slot(last)) link_after(f, last);
      else if (valid_slot(used_head)) begin
        nxt[f[4:0]] = used_head;
        prv[f[4:0]] = NONE;
        prv[used_head[4:0]] = f;
        used_head = f;
      end else begin
        used_head = f;
        nxt[f[4:0]] = NONE;
        prv[f[4:0]] = NONE;
      end
      start_addr[f[4:0]] = {rq.rom_address[31:1], 1'b0};
      last_frame[f[4:0]] = frame_cnt;
      r.slot = f[4:0];
      r.offset = 12'(delta);
      r.dma_start = 1'b1;
      r.dma_source = {rq.rom_address[31:1], 1'b0};
      r.dma_tag = dma_cnt;
      if (dma_cnt < 8'd255) dma_cnt++;
      pending.push_back(r);
    endfunction

    function void check_result(sdbc_pkg::res_t got);
      sdbc_pkg::res_t want;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("Mismatch: expected %p, actual %p", want, got);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [7:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  sdbc_pkg::req_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  sdbc_pkg::res_t out_data_o;

  slot_cache_scoreboard sb = new();
  int cycles = 0;
  bit quiet = 1'b0;
  int sent = 0;
  int ticks = 0;
  logic [31:0] hot_base;

  always #2 clk_i = ~clk_i;

  sample_dma_buffer_cache_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int burst;
    @(negedge clk_i);
    forever begin
      if (!quiet && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 15);
        out_stall_i <= 1'b1;
        repeat (burst) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      @(negedge clk_i);
    end
  end

  task automatic send(sdbc_pkg::req_t rq);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_data_i <= rq;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(rq);
    sent++;
    if (rq.op == sdbc_pkg::OP_TICK) ticks++;
    @(negedge clk_i);
  endtask

  task automatic fetch(logic [31:0] a, logic [15:0] len);
    sdbc_pkg::req_t rq;
    rq.op = sdbc_pkg::OP_FETCH;
    rq.rom_address = a;
    rq.byte_length = len;
    send(rq);
  endtask

  task automatic tick();
    sdbc_pkg::req_t rq;
    rq.op = sdbc_pkg::OP_TICK;
    rq.rom_address = $urandom;
    rq.byte_length = 16'($urandom);
    send(rq);
  endtask

  task automatic drain_and_set_lag(logic [7:0] v);
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (120) @(negedge clk_i);
    cfg_wdata_i <= v;
    cfg_we_i <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.lag = v;
  endtask

  task automatic random_item();
    int k;
    k = $urandom_range(0, 99);
    if (k < 12) tick();
    else if (k < 55)
      fetch(hot_base + $urandom_range(0, 40000), 16'($urandom_range(0, 2100)));
    else if (k < 80)
      fetch(hot_base + $urandom_range(0, 40000), 16'($urandom_range(0, 300)));
    else if (k < 90) fetch($urandom, 16'($urandom));
    else fetch(32'hFFFF_F000 + $urandom_range(0, 4095), 16'($urandom));
  endtask

  initial begin
    sb.reset_state();
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    fetch(32'h0000_1001, 16'd0);
    fetch(32'h0000_1001, 16'd2047);
    fetch(32'h0000_1000, 16'd2048);
    fetch(32'h0000_1800, 16'd0);
    fetch(32'h0000_1000, 16'd2049);
    fetch(32'h0000_0000, 16'hFFFF);
    fetch(32'hFFFF_FFFF, 16'hFFFF);
    fetch(32'hFFFF_F801, 16'd2047);
    fetch(32'h0000_0800, 16'd16);
    tick();
    tick();
    tick();
    tick();
    fetch(32'h0000_1001, 16'd4);
    for (int i = 0; i < 10; i++) fetch(32'h0010_0000 + i * 32'h1000, 16'd8);

    drain_and_set_lag(8'd255);
    hot_base = 32'h0004_0000;
    for (int i = 0; i < 300; i++) random_item();
    for (int i = 0; i < 40; i++) fetch(32'h0100_0000 + i * 32'h1000, 16'd1);

    drain_and_set_lag(8'd0);
    hot_base = $urandom;
    for (int i = 0; i < 250; i++) random_item();

    drain_and_set_lag(8'($urandom_range(2, 6)));
    hot_base = $urandom_range(0, 32'h7FFF_FFFF);
    for (int i = 0; i < 150; i++) random_item();

    quiet = 1'b1;
    for (int i = 0; i < 120; i++) random_item();
    in_valid_i <= 1'b0;

    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (120) @(negedge clk_i);
    $display("Sent %0d transactions (%0d frame ticks), checked %0d results.",
             sent, ticks, sb.checked);
    $display("Frame lag settings covered 1, 255, 0 and a small random value.");
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/sdbc_pkg.sv
rtl/sample_dma_buffer_cache_unit.sv
verif/sample_dma_buffer_cache_unit_test.sv
